>>> hdl/apcu_pkg.sv
package apcu_pkg;

  // Depth of the command queue between the front and the back end.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // Item kinds.
  localparam logic KIND_KEY   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Printable range and the keys with special handling.
  localparam logic [6:0] KEY_FIRST_PRINT = 7'h20;
  localparam logic [6:0] KEY_LAST_PRINT  = 7'h7e;
  localparam logic [6:0] KEY_DIGIT_0     = 7'h30;
  localparam logic [6:0] KEY_DIGIT_9     = 7'h39;
  localparam logic [6:0] KEY_EXCLAIM     = 7'h21;
  localparam logic [6:0] KEY_DQUOTE      = 7'h22;
  localparam logic [6:0] KEY_DOLLAR      = 7'h24;
  localparam logic [6:0] KEY_SQUOTE      = 7'h27;
  localparam logic [6:0] KEY_LPAREN      = 7'h28;
  localparam logic [6:0] KEY_RPAREN      = 7'h29;
  localparam logic [6:0] KEY_COMMA       = 7'h2c;
  localparam logic [6:0] KEY_PERIOD      = 7'h2e;
  localparam logic [6:0] KEY_COLON       = 7'h3a;
  localparam logic [6:0] KEY_SEMI        = 7'h3b;
  localparam logic [6:0] KEY_LESS        = 7'h3c;
  localparam logic [6:0] KEY_GREATER     = 7'h3e;
  localparam logic [6:0] KEY_QUESTION    = 7'h3f;
  localparam logic [6:0] KEY_LBRACKET    = 7'h5b;
  localparam logic [6:0] KEY_BACKSLASH   = 7'h5c;
  localparam logic [6:0] KEY_RBRACKET    = 7'h5d;
  localparam logic [6:0] KEY_CARET       = 7'h5e;
  localparam logic [6:0] KEY_UNDERSCORE  = 7'h5f;
  localparam logic [6:0] KEY_BACKTICK    = 7'h60;
  localparam logic [6:0] KEY_LBRACE      = 7'h7b;
  localparam logic [6:0] KEY_RBRACE      = 7'h7d;
  localparam logic [6:0] KEY_TILDE       = 7'h7e;

  // One queued command. A converted command carries a three-byte pattern;
  // rep sends it twice. A two-byte sequence is marked by a zero third byte.
  typedef struct packed {
    logic       conv;
    logic       rep;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } cmd_t;

  // Maps a printable key to its substitute sequence, given the kept state.
  function automatic cmd_t map_key(input logic [6:0] key, input logic after_digit,
                                   input logic sq_open, input logic dq_open);
    cmd_t c;
    c.conv = 1'b1;
    c.rep  = 1'b0;
    {c.b0, c.b1, c.b2} = 24'h000000;
    case (key)
      KEY_BACKTICK:   {c.b0, c.b1, c.b2} = 24'hc2b700;
      KEY_TILDE:      {c.b0, c.b1, c.b2} = 24'hefbd9e;
      KEY_EXCLAIM:    {c.b0, c.b1, c.b2} = 24'hefbc81;
      KEY_DOLLAR:     {c.b0, c.b1, c.b2} = 24'hefbfa5;
      KEY_CARET: begin
        {c.b0, c.b1, c.b2} = 24'he280a6;
        c.rep = 1'b1;
      end
      KEY_LPAREN:     {c.b0, c.b1, c.b2} = 24'hefbc88;
      KEY_RPAREN:     {c.b0, c.b1, c.b2} = 24'hefbc89;
      KEY_UNDERSCORE: begin
        {c.b0, c.b1, c.b2} = 24'he28094;
        c.rep = 1'b1;
      end
      KEY_LBRACKET:   {c.b0, c.b1, c.b2} = 24'he38090;
      KEY_RBRACKET:   {c.b0, c.b1, c.b2} = 24'he38091;
      KEY_LBRACE:     {c.b0, c.b1, c.b2} = 24'he3808e;
      KEY_RBRACE:     {c.b0, c.b1, c.b2} = 24'he3808f;
      KEY_BACKSLASH:  {c.b0, c.b1, c.b2} = 24'he38081;
      KEY_SEMI:       {c.b0, c.b1, c.b2} = 24'hefbc9b;
      KEY_COLON:      {c.b0, c.b1, c.b2} = 24'hefbc9a;
      KEY_SQUOTE:     {c.b0, c.b1, c.b2} = sq_open ? 24'he28098 : 24'he28099;
      KEY_DQUOTE:     {c.b0, c.b1, c.b2} = dq_open ? 24'he2809c : 24'he2809d;
      KEY_COMMA: begin
        {c.b0, c.b1, c.b2} = 24'hefbc8c;
        c.conv = !after_digit;
      end
      KEY_PERIOD: begin
        {c.b0, c.b1, c.b2} = 24'he38082;
        c.conv = !after_digit;
      end
      KEY_LESS:       {c.b0, c.b1, c.b2} = 24'he3808a;
      KEY_GREATER:    {c.b0, c.b1, c.b2} = 24'he3808b;
      KEY_QUESTION:   {c.b0, c.b1, c.b2} = 24'hefbc9f;
      default:        c.conv = 1'b0;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/apcu_if.sv
// Input channel: one key press or clear command per word.
interface apcu_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] key_code;
  modport source (output valid, output kind, output key_code, input ready);
  modport sink (input valid, input kind, input key_code, output ready);
endinterface

// Output channel: one UTF-8 byte or pass-through marker per word.
interface apcu_out_if;
  logic       valid;
  logic       ready;
  logic       converted;
  logic [7:0] out_byte;
  logic       last;
  modport source (output valid, output converted, output out_byte, output last,
                  input ready);
  modport sink (input valid, input converted, input out_byte, input last,
                output ready);
endinterface

// Configuration channel: write data of the mode register.
interface apcu_cfg_if;
  logic valid;
  logic ready;
  logic chinese_mode;
  modport source (output valid, output chinese_mode, input ready);
  modport sink (input valid, input chinese_mode, output ready);
endinterface

>>> hdl/apcu_front.sv
module apcu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  apcu_in_if.sink            in_i,
  apcu_cfg_if.sink           cfg_i,
  input  logic               full_i,
  output logic               push_o,
  output apcu_pkg::cmd_t     cmd_o
);

  logic       mode_q;
  logic       sq_open_q, sq_open_d;
  logic       dq_open_q, dq_open_d;
  logic [6:0] last_key_q, last_key_d;
  logic [6:0] key7;
  logic       printable;
  logic       after_digit;
  logic       accept;
  apcu_pkg::cmd_t cmd;

  // Configuration is always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (cfg_i.valid) begin
      mode_q <= cfg_i.chinese_mode;
    end
  end

  // Classification of the incoming key.
  assign key7        = in_i.key_code[6:0];
  assign printable   = (in_i.key_code[15:7] == 9'd0) && (key7 >= apcu_pkg::KEY_FIRST_PRINT) &&
                       (key7 <= apcu_pkg::KEY_LAST_PRINT);
  assign after_digit = (last_key_q >= apcu_pkg::KEY_DIGIT_0) &&
                       (last_key_q <= apcu_pkg::KEY_DIGIT_9);

  always_comb begin
    cmd = '0;
    if (mode_q && printable) begin
      cmd = apcu_pkg::map_key(key7, after_digit, sq_open_q, dq_open_q);
    end
  end

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign push_o     = accept && (in_i.kind == apcu_pkg::KIND_KEY);
  assign cmd_o      = cmd;

  // Quote flags and last recorded key follow each accepted word.
  always_comb begin
    sq_open_d  = sq_open_q;
    dq_open_d  = dq_open_q;
    last_key_d = last_key_q;
    if (accept) begin
      if (in_i.kind == apcu_pkg::KIND_CLEAR) begin
        sq_open_d  = 1'b1;
        dq_open_d  = 1'b1;
        last_key_d = 7'd0;
      end else if (printable) begin
        if (!cmd.conv) begin
          last_key_d = key7;
        end else if (key7 == apcu_pkg::KEY_SQUOTE) begin
          sq_open_d = !sq_open_q;
        end else if (key7 == apcu_pkg::KEY_DQUOTE) begin
          dq_open_d = !dq_open_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_open_q  <= 1'b1;
      dq_open_q  <= 1'b1;
      last_key_q <= 7'd0;
    end else begin
      sq_open_q  <= sq_open_d;
      dq_open_q  <= dq_open_d;
      last_key_q <= last_key_d;
    end
  end

endmodule

>>> hdl/apcu_queue.sv
module apcu_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  apcu_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output apcu_pkg::cmd_t head_o
);

  apcu_pkg::cmd_t             mem_q [apcu_pkg::QDEPTH];
  logic [apcu_pkg::QAW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [apcu_pkg::QCW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == apcu_pkg::QCW'(apcu_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Storage is written only at the tail.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == apcu_pkg::QAW'(apcu_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == apcu_pkg::QAW'(apcu_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

>>> hdl/apcu_back.sv
module apcu_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  apcu_pkg::cmd_t head_i,
  output logic           pop_o,
  apcu_out_if.source     out_o
);

  logic       valid_q;
  logic       conv_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic [1:0] pos_q, pos_d;
  logic       half_q, half_d;
  logic       load;
  logic       last_d;
  logic       seq_end;
  logic [7:0] sel_byte;

  // A new word enters the output register when it is empty or being taken.
  assign load = !empty_i && (!valid_q || out_o.ready);

  // A sequence ends after its third byte, or after its second when the third is zero.
  assign seq_end = (pos_q == 2'd2) || ((pos_q == 2'd1) && (head_i.b2 == 8'd0));
  assign last_d  = !head_i.conv || (seq_end && (!head_i.rep || half_q));
  assign pop_o   = load && last_d;

  always_comb begin
    case (pos_q)
      2'd0:    sel_byte = head_i.b0;
      2'd1:    sel_byte = head_i.b1;
      default: sel_byte = head_i.b2;
    endcase
  end

  // Byte position within the pattern and the repeat half.
  always_comb begin
    pos_d  = pos_q;
    half_d = half_q;
    if (load) begin
      if (last_d) begin
        pos_d  = 2'd0;
        half_d = 1'b0;
      end else if (seq_end) begin
        pos_d  = 2'd0;
        half_d = 1'b1;
      end else begin
        pos_d = pos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= 2'd0;
      half_q  <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      half_q <= half_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output word payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      conv_q <= head_i.conv;
      byte_q <= head_i.conv ? sel_byte : 8'd0;
      last_q <= last_d;
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.converted = conv_q;
  assign out_o.out_byte  = byte_q;
  assign out_o.last      = last_q;

endmodule

>>> hdl/ascii_punct_to_cjk_utf8_top.sv
// Channel | Direction | Word contents
// in_i    | sink      | kind, key_code (one key press or clear command)
// out_o   | source    | converted, out_byte, last (one result byte)
// cfg_i   | sink      | chinese_mode (always ready)
//
// The front end classifies a word in the cycle it is accepted and queues one
// command; a clear word updates state and queues nothing.
// The back end sends one result word per cycle while out_o is ready; a key
// gives 1, 2, 3 or 6 words, and the output register sets the sustained rate.
// Input is accepted while the two-entry command queue has room, so the front
// keeps taking words while the output stalls. Reset is asynchronous and low.
module ascii_punct_to_cjk_utf8_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  apcu_in_if.sink    in_i,
  apcu_cfg_if.sink   cfg_i,
  apcu_out_if.source out_o
);

  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  apcu_pkg::cmd_t cmd;
  apcu_pkg::cmd_t head;

  apcu_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd)
  );

  apcu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  apcu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

>>> hdl/apcu_checker.sv
module apcu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_converted_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i
);

  // A stalled output word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word withdrawn while stalled");

  // A pass-through word carries a zero byte and ends its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_converted_i |-> (out_byte_i == 8'd0) && out_last_i)
    else $error("pass-through word malformed");

  // The rest of a sequence follows right after a non-final byte is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i && out_converted_i)
    else $error("gap inside a UTF-8 sequence");

endmodule

bind ascii_punct_to_cjk_utf8_top apcu_checker u_apcu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_converted_i (out_o.converted),
  .out_byte_i      (out_o.out_byte),
  .out_last_i      (out_o.last)
);
